// ----- rtl/core/cle_pkg.sv -----
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types and constants of the command line editor: key codes, result
// kinds, datapath commands and the status passed back to the controller.
// ----------------------------------------------------------------------------
package cle_pkg;

    localparam int LINE_SIZE = 64;
    localparam int ADDR_W    = (LINE_SIZE > 1) ? $clog2(LINE_SIZE) : 1;
    localparam int LEN_W     = 6;
    localparam int KEY_W     = 8;
    localparam int KIND_W    = 2;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_SIZE - 1);

    localparam logic [KEY_W-1:0] KEY_NUL       = 8'h00;
    localparam logic [KEY_W-1:0] KEY_HIST_UP   = 8'h01;
    localparam logic [KEY_W-1:0] KEY_HIST_DOWN = 8'h02;
    localparam logic [KEY_W-1:0] KEY_LEFT      = 8'h03;
    localparam logic [KEY_W-1:0] KEY_RIGHT     = 8'h04;
    localparam logic [KEY_W-1:0] KEY_BACKSPACE = 8'h08;
    localparam logic [KEY_W-1:0] KEY_ENTER     = 8'h0A;

    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CHAR   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

    typedef enum logic [2:0] {
        KC_NOP,
        KC_CHAR,
        KC_ENTER,
        KC_BKSP,
        KC_LEFT,
        KC_RIGHT
    } key_class_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_INS_START,
        CMD_SHR_STEP,
        CMD_INS_PUT,
        CMD_DEL_START,
        CMD_SHL_STEP,
        CMD_DEL_DONE,
        CMD_LEFT,
        CMD_RIGHT,
        CMD_COMMIT_START,
        CMD_COMMIT_RD,
        CMD_EMIT_CHAR,
        CMD_EMIT_STATUS,
        CMD_EMIT_EMPTY
    } cmd_t;

    typedef struct packed {
        key_class_t key_class;
        logic       len_zero;
        logic       cur_zero;
        logic       cur_at_end;
        logic       line_full;
        logic       shr_done;
        logic       shl_done;
        logic       commit_last;
        logic       out_free;
    } cle_stat_t;

endpackage

// ----- rtl/core/cle_dpath.sv -----
// ----------------------------------------------------------------------------
// cle_dpath
// Line store, length, cursor, walk index and output register. Executes one
// command from the controller per cycle.
// ----------------------------------------------------------------------------
module cle_dpath
    import cle_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [KEY_W-1:0]      key,
    input  cmd_t                  cmd,
    output cle_stat_t             stat,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [KIND_W-1:0]     kind,
    output logic [KEY_W-1:0]      char_out,
    output logic [LEN_W-1:0]      length_now,
    output logic [LEN_W-1:0]      cursor_now,
    output logic                  last
);

    logic [KEY_W-1:0]  mem [LINE_SIZE];

    logic [KEY_W-1:0]  key_reg;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  cur_reg, cur_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;
    logic [KEY_W-1:0]  rd_data_reg;
    logic              wb_pend_reg, wb_pend_next;
    logic [LEN_W-1:0]  wb_addr_reg, wb_addr_next;

    logic              out_valid_reg, out_valid_next;
    logic [KIND_W-1:0] kind_reg;
    logic [KEY_W-1:0]  char_reg;
    logic [LEN_W-1:0]  lenout_reg;
    logic [LEN_W-1:0]  curout_reg;
    logic              last_reg;

    logic              rd_en;
    logic [LEN_W-1:0]  rd_addr;
    logic              wr_en;
    logic [LEN_W-1:0]  wr_addr;
    logic [KEY_W-1:0]  wr_data;
    logic              out_load;
    logic [LEN_W:0]    idx_inc;
    logic [LEN_W-1:0]  idx_dec;
    key_class_t        key_class;

    assign idx_inc = {1'b0, idx_reg} + {{LEN_W{1'b0}}, 1'b1};
    assign idx_dec = idx_reg - LEN_W'(1);

    always_comb
    begin
        case (key)
            KEY_ENTER:                       key_class = KC_ENTER;
            KEY_BACKSPACE:                   key_class = KC_BKSP;
            KEY_LEFT:                        key_class = KC_LEFT;
            KEY_RIGHT:                       key_class = KC_RIGHT;
            KEY_NUL, KEY_HIST_UP, KEY_HIST_DOWN: key_class = KC_NOP;
            default:                         key_class = KC_CHAR;
        endcase
    end

    assign stat.key_class   = key_class;
    assign stat.len_zero    = (len_reg == '0);
    assign stat.cur_zero    = (cur_reg == '0);
    assign stat.cur_at_end  = (cur_reg == len_reg);
    assign stat.line_full   = (len_reg >= LEN_MAX);
    assign stat.shr_done    = (idx_reg == cur_reg);
    assign stat.shl_done    = (idx_inc >= {1'b0, len_reg});
    assign stat.commit_last = (idx_inc == {1'b0, len_reg});
    assign stat.out_free    = !out_valid_reg || !out_stall;

    // read port and walk index
    always_comb
    begin
        rd_en        = 1'b0;
        rd_addr      = idx_reg;
        idx_next     = idx_reg;
        len_next     = len_reg;
        cur_next     = cur_reg;
        wb_pend_next = 1'b0;
        wb_addr_next = wb_addr_reg;
        out_load     = 1'b0;
        case (cmd)
            CMD_INS_START:    idx_next = len_reg;
            CMD_SHR_STEP:
            begin
                rd_en        = 1'b1;
                rd_addr      = idx_dec;
                wb_pend_next = 1'b1;
                wb_addr_next = idx_reg;
                idx_next     = idx_dec;
            end
            CMD_INS_PUT:
            begin
                len_next = len_reg + LEN_W'(1);
                cur_next = cur_reg + LEN_W'(1);
            end
            CMD_DEL_START:    idx_next = cur_reg - LEN_W'(1);
            CMD_SHL_STEP:
            begin
                rd_en        = 1'b1;
                rd_addr      = idx_inc[LEN_W-1:0];
                wb_pend_next = 1'b1;
                wb_addr_next = idx_reg;
                idx_next     = idx_inc[LEN_W-1:0];
            end
            CMD_DEL_DONE:
            begin
                len_next = len_reg - LEN_W'(1);
                cur_next = cur_reg - LEN_W'(1);
            end
            CMD_LEFT:         cur_next = cur_reg - LEN_W'(1);
            CMD_RIGHT:        cur_next = cur_reg + LEN_W'(1);
            CMD_COMMIT_START: idx_next = '0;
            CMD_COMMIT_RD:    rd_en = 1'b1;
            CMD_EMIT_CHAR:
            begin
                out_load = 1'b1;
                // prefetch the next character while this one goes out
                rd_en    = 1'b1;
                rd_addr  = idx_inc[LEN_W-1:0];
                idx_next = idx_inc[LEN_W-1:0];
                if (stat.commit_last)
                begin
                    len_next = '0;
                    cur_next = '0;
                end
            end
            CMD_EMIT_STATUS:  out_load = 1'b1;
            CMD_EMIT_EMPTY:   out_load = 1'b1;
            default:          ;
        endcase
    end

    // a pending shift write always wins; the inserted key goes in after the drain
    assign wr_en   = wb_pend_reg || (cmd == CMD_INS_PUT);
    assign wr_addr = wb_pend_reg ? wb_addr_reg : cur_reg;
    assign wr_data = wb_pend_reg ? rd_data_reg : key_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr[ADDR_W-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd == CMD_INS_START)
        begin
            key_reg <= key;
        end
        wb_addr_reg <= wb_addr_next;
        idx_reg     <= idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            cur_reg       <= '0;
            wb_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            cur_reg       <= cur_next;
            wb_pend_reg   <= wb_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            case (cmd)
                CMD_EMIT_CHAR:
                begin
                    kind_reg   <= KIND_CHAR;
                    char_reg   <= rd_data_reg;
                    lenout_reg <= '0;
                    curout_reg <= '0;
                    last_reg   <= stat.commit_last;
                end
                CMD_EMIT_EMPTY:
                begin
                    kind_reg   <= KIND_EMPTY;
                    char_reg   <= '0;
                    lenout_reg <= '0;
                    curout_reg <= '0;
                    last_reg   <= 1'b1;
                end
                default:
                begin
                    kind_reg   <= KIND_STATUS;
                    char_reg   <= '0;
                    lenout_reg <= len_reg;
                    curout_reg <= cur_reg;
                    last_reg   <= 1'b1;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign char_out   = char_reg;
    assign length_now = lenout_reg;
    assign cursor_now = curout_reg;
    assign last       = last_reg;

`ifndef SYNTHESIS
    a_cur_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg <= len_reg)
        else $error("cursor beyond line length");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_MAX)
        else $error("line length beyond capacity");

    a_no_wr_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(wb_pend_reg && cmd == CMD_INS_PUT))
        else $error("key write collides with shift write");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || !out_stall))
        else $error("result register overwritten while stalled");
`endif

endmodule

// ----- rtl/core/cle_ctrl.sv -----
// ----------------------------------------------------------------------------
// cle_ctrl
// Editor sequencer: decodes the accepted key and steps the datapath through
// insert, delete and commit walks, then issues the result beats.
// ----------------------------------------------------------------------------
module cle_ctrl
    import cle_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  cle_stat_t stat,
    output cmd_t      cmd
);

    typedef enum logic [7:0] {
        S_IDLE       = 8'b0000_0001,
        S_SHR        = 8'b0000_0010,
        S_PUT        = 8'b0000_0100,
        S_SHL        = 8'b0000_1000,
        S_COMMIT_RD  = 8'b0001_0000,
        S_COMMIT_OUT = 8'b0010_0000,
        S_STATUS     = 8'b0100_0000,
        S_EMPTY      = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_STATUS;
                    case (stat.key_class)
                        KC_ENTER:
                        begin
                            if (stat.len_zero)
                            begin
                                state_next = S_EMPTY;
                            end
                            else
                            begin
                                cmd        = CMD_COMMIT_START;
                                state_next = S_COMMIT_RD;
                            end
                        end
                        KC_BKSP:
                        begin
                            if (!stat.cur_zero)
                            begin
                                cmd        = CMD_DEL_START;
                                state_next = S_SHL;
                            end
                        end
                        KC_LEFT:
                        begin
                            if (!stat.cur_zero)
                            begin
                                cmd = CMD_LEFT;
                            end
                        end
                        KC_RIGHT:
                        begin
                            if (!stat.cur_at_end)
                            begin
                                cmd = CMD_RIGHT;
                            end
                        end
                        KC_CHAR:
                        begin
                            if (!stat.line_full)
                            begin
                                cmd        = CMD_INS_START;
                                state_next = S_SHR;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SHR:
            begin
                // last shift write drains on the exit cycle
                if (stat.shr_done)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    cmd = CMD_SHR_STEP;
                end
            end
            S_PUT:
            begin
                cmd        = CMD_INS_PUT;
                state_next = S_STATUS;
            end
            S_SHL:
            begin
                if (stat.shl_done)
                begin
                    cmd        = CMD_DEL_DONE;
                    state_next = S_STATUS;
                end
                else
                begin
                    cmd = CMD_SHL_STEP;
                end
            end
            S_COMMIT_RD:
            begin
                cmd        = CMD_COMMIT_RD;
                state_next = S_COMMIT_OUT;
            end
            S_COMMIT_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd = CMD_EMIT_CHAR;
                    if (stat.commit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_STATUS:
            begin
                if (stat.out_free)
                begin
                    cmd        = CMD_EMIT_STATUS;
                    state_next = S_IDLE;
                end
            end
            S_EMPTY:
            begin
                if (stat.out_free)
                begin
                    cmd        = CMD_EMIT_EMPTY;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/core/command_line_editor_top.sv -----
// ----------------------------------------------------------------------------
// command_line_editor_top
// Line editing buffer with cursor: insert, backspace, cursor moves, commit.
// ----------------------------------------------------------------------------
// One key byte is taken per beat. Edits, cursor moves and ignored keys give one status beat
// with the new length and cursor; enter gives one beat per stored character
// (last set on the final one), or one empty-line beat, and clears the line.
// The line store is a single-write, single-read memory walked one entry per
// cycle; the commit walk waits while the output register is stalled. The key
// after a result may be taken while that result still sits in the output
// register.
module command_line_editor_top
    import cle_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [KEY_W-1:0]  key,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [KIND_W-1:0] kind,
    output logic [KEY_W-1:0]  char_out,
    output logic [LEN_W-1:0]  length_now,
    output logic [LEN_W-1:0]  cursor_now,
    output logic              last
);

    cmd_t      cmd;
    cle_stat_t stat;

    cle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    cle_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .key        (key),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .char_out   (char_out),
        .length_now (length_now),
        .cursor_now (cursor_now),
        .last       (last)
    );

endmodule

// ----- tb/command_line_editor_top_tb.sv -----
// ----------------------------------------------------------------------------
// command_line_editor_top_tb
// Self-checking bench for the line editor: key beats go in, and every
// status, character or empty-line beat that comes out is checked against a
// behavioral copy of the line, its length and its cursor. Both sides idle
// and stall at random, the receiver holds off for a long stretch once, and
// one phase runs with no idling at all.
// ----------------------------------------------------------------------------
module command_line_editor_top_tb;
    import cle_pkg::*;

    localparam int QUIET_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_PRINTS   = 20;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  ch;
        logic [LEN_W-1:0]  len;
        logic [LEN_W-1:0]  cur;
        logic              last;
    } editor_beat_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [KEY_W-1:0]  key = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  char_out;
    logic [LEN_W-1:0]  length_now;
    logic [LEN_W-1:0]  cursor_now;
    logic              last;

    // shadow copy of the editor state
    logic [KEY_W-1:0]  line_buf [0:LINE_SIZE-1];
    logic [LEN_W-1:0]  line_len = '0;
    logic [LEN_W-1:0]  line_cur = '0;
    editor_beat_t      beat_q [$];

    logic idle_en  = 1'b1;
    logic stall_en = 1'b1;
    logic hold_out = 1'b0;

    int keys_sent       = 0;
    int beats_checked   = 0;
    int lines_committed = 0;
    int mismatches      = 0;
    int quiet_cycles    = 0;

    command_line_editor_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .key        (key),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .char_out   (char_out),
        .length_now (length_now),
        .cursor_now (cursor_now),
        .last       (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    function automatic void push_beat(input logic [KIND_W-1:0] k, input logic [KEY_W-1:0] c,
                                      input logic [LEN_W-1:0] l, input logic [LEN_W-1:0] p,
                                      input logic lst);
        editor_beat_t b;
        b.kind = k;
        b.ch   = c;
        b.len  = l;
        b.cur  = p;
        b.last = lst;
        beat_q.push_back(b);
    endfunction

    // apply one key to the shadow line and queue the beats it must produce
    function automatic void apply_key(input logic [KEY_W-1:0] k);
        int i;
        if (k == KEY_ENTER)
        begin
            if (line_len == 0)
                push_beat(KIND_EMPTY, '0, '0, '0, 1'b1);
            else
                for (i = 0; i < int'(line_len); i++)
                    push_beat(KIND_CHAR, line_buf[i], '0, '0, i == int'(line_len) - 1);
            line_len = '0;
            line_cur = '0;
            lines_committed++;
            return;
        end
        if (k == KEY_BACKSPACE)
        begin
            if (line_cur != 0 && line_len != 0)
            begin
                for (i = int'(line_cur) - 1; i + 1 < int'(line_len); i++)
                    line_buf[i] = line_buf[i + 1];
                line_len--;
                line_cur--;
            end
        end
        else if (k == KEY_LEFT)
        begin
            if (line_cur > 0)
                line_cur--;
        end
        else if (k == KEY_RIGHT)
        begin
            if (line_cur < line_len)
                line_cur++;
        end
        else if (k != KEY_NUL && k != KEY_HIST_UP && k != KEY_HIST_DOWN)
        begin
            // dropped when the line is full; the status beat still follows
            if (line_len < LEN_MAX)
            begin
                for (i = int'(line_len); i > int'(line_cur); i--)
                    line_buf[i] = line_buf[i - 1];
                line_buf[line_cur] = k;
                line_len++;
                line_cur++;
            end
        end
        push_beat(KIND_STATUS, '0, line_len, line_cur, 1'b1);
    endfunction

    function automatic logic [KEY_W-1:0] random_text_byte();
        logic [KEY_W-1:0] k;
        do
            k = KEY_W'($urandom_range(0, 255));
        while (k == KEY_NUL || k == KEY_HIST_UP || k == KEY_HIST_DOWN || k == KEY_LEFT ||
               k == KEY_RIGHT || k == KEY_BACKSPACE || k == KEY_ENTER);
        return k;
    endfunction

    task automatic send_key(input logic [KEY_W-1:0] k);
        while (idle_en && $urandom_range(0, 99) < 34)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        key      <= k;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        apply_key(k);
        keys_sent++;
    endtask

    // receiver side: random stall, or a solid hold-off when asked
    always @(posedge clk)
    begin
        if (hold_out)
            out_stall <= 1'b1;
        else if (stall_en)
            out_stall <= ($urandom_range(0, 99) < 34);
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin : check_beat
        editor_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            beats_checked++;
            if (beat_q.size() == 0)
                report_mismatch($sformatf("unexpected beat kind %0d char %02h", kind, char_out));
            else
            begin
                want = beat_q.pop_front();
                if (kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
                if (char_out !== want.ch)
                    report_mismatch($sformatf("char_out %02h, want %02h", char_out, want.ch));
                if (length_now !== want.len)
                    report_mismatch($sformatf("length_now %0d, want %0d", length_now, want.len));
                if (cursor_now !== want.cur)
                    report_mismatch($sformatf("cursor_now %0d, want %0d", cursor_now, want.cur));
                if (last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b", last, want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
            $display("command_line_editor_top regression: fail");
            $finish;
        end
    end

    // corner keys on an empty and a short line
    task automatic test_special_keys();
        logic [KEY_W-1:0] seq [] = '{
            KEY_ENTER, KEY_BACKSPACE, KEY_LEFT, KEY_RIGHT, KEY_NUL, KEY_HIST_UP,
            KEY_HIST_DOWN, 8'hFF, 8'h20, 8'h7E, 8'h05, KEY_LEFT, KEY_LEFT, 8'h80,
            KEY_RIGHT, KEY_BACKSPACE, KEY_RIGHT, KEY_RIGHT, 8'h09, KEY_LEFT,
            KEY_LEFT, KEY_LEFT, KEY_LEFT, KEY_LEFT, KEY_BACKSPACE, KEY_ENTER
        };
        foreach (seq[i])
            send_key(seq[i]);
    endtask

    // fill the line, overflow it at the end and in the middle, commit all of it
    task automatic test_full_line();
        int i;
        for (i = 0; i < int'(LEN_MAX); i++)
            send_key(i == 0 ? 8'hFF : (i == 1 ? 8'h80 : random_text_byte()));
        send_key(8'h41);
        send_key(KEY_RIGHT);
        repeat (3)
            send_key(KEY_LEFT);
        send_key(8'h42);
        send_key(KEY_BACKSPACE);
        send_key(8'h43);
        send_key(8'h44);
        send_key(KEY_ENTER);
    endtask

    // edit sessions with random content, bursts of typing and some noise
    task automatic test_random_editing(input int n_keys);
        int sent;
        int r;
        int n;
        sent = 0;
        while (sent < n_keys)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
            begin
                n = $urandom_range(30, 70);
                repeat (n)
                    send_key(random_text_byte());
                sent += n;
            end
            else
            begin
                if (r < 8)
                    send_key(KEY_W'($urandom_range(0, 255)));
                else if (r < 60)
                    send_key(random_text_byte());
                else if (r < 70)
                    send_key(KEY_LEFT);
                else if (r < 78)
                    send_key(KEY_RIGHT);
                else if (r < 88)
                    send_key(KEY_BACKSPACE);
                else if (r < 92)
                    send_key(KEY_W'($urandom_range(0, 2)));
                else
                    send_key(KEY_ENTER);
                sent++;
            end
        end
        send_key(KEY_ENTER);
    endtask

    // receiver holds off while keys keep coming, so the input backs up
    task automatic test_output_hold_off();
        fork
            begin
                hold_out <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                hold_out <= 1'b0;
            end
        join_none
        repeat (12)
            send_key(random_text_byte());
        send_key(KEY_LEFT);
        send_key(KEY_BACKSPACE);
        send_key(KEY_ENTER);
        repeat (20)
            send_key(random_text_byte());
        send_key(KEY_ENTER);
        wait fork;
    endtask

    // no idling on either side
    task automatic test_back_to_back();
        idle_en  = 1'b0;
        stall_en = 1'b0;
        test_random_editing(60);
        idle_en  = 1'b1;
        stall_en = 1'b1;
    endtask

    initial
    begin
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_special_keys();
        test_full_line();
        test_random_editing(230);
        test_output_hold_off();
        test_back_to_back();
        in_valid <= 1'b0;

        while (beat_q.size() != 0)
            @(posedge clk);
        repeat (80)
            @(posedge clk);

        $display("covered %0d keys, %0d result beats, %0d committed lines",
                 keys_sent, beats_checked, lines_committed);
        $display("included full-line drops, cursor limits, ignored keys and a long output hold-off");
        if (mismatches == 0)
            $display("command_line_editor_top regression: pass");
        else
            $display("command_line_editor_top regression: fail");
        $finish;
    end

endmodule
